@@ rtl/thermistor_table_linearizer_assert.svh @@
// Assertion macros for the thermistor table linearizer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef THERMISTOR_TABLE_LINEARIZER_ASSERT_SVH
`define THERMISTOR_TABLE_LINEARIZER_ASSERT_SVH

// same-cycle implication
`define TLIN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLIN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tlin_pkg.sv @@
// Shared types and constants of the thermistor table linearizer.
// No dependencies; used by the divider and the top level.
package tlin_pkg;

    // request codes
    localparam logic [1:0] REQ_LOAD      = 2'd0;
    localparam logic [1:0] REQ_CONVERT   = 2'd1;
    localparam logic [1:0] REQ_CALIBRATE = 2'd2;

    // reference modes
    localparam logic [1:0] MODE_SUPPLY = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;   // behaves as MODE_DOUBLE

    // register indexes
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_REF_MODE      = 2'd1;
    localparam logic [1:0] REG_DIV_TOP       = 2'd2;
    localparam logic [1:0] REG_DIV_BOTTOM    = 2'd3;

    localparam int APB_AW = 4;
    localparam int ADC_FULL_SCALE = 1024;

    // datapath widths
    localparam int VCC_W = 27;   // supply sample times divider sum
    localparam int DIV_NW = 46;  // dividend / quotient
    localparam int DIV_DW = 29;  // divisor
    localparam int RES_W = 29;   // resistance minus table entry

    localparam logic signed [10:0] CAL_SCALE = 11'sd1000;
    localparam int CAL_MIN = -120;
    localparam int CAL_MAX = 120;
    localparam int TEMP_MAX = 32767;
    localparam int TEMP_MIN = -32768;

    typedef enum logic [4:0] {
        S_IDLE, S_VCC, S_VCC_WAIT, S_RD0, S_RD1, S_RD2, S_RES, S_RES_WAIT,
        S_RD3, S_RD4, S_CUR, S_CHK, S_NXT, S_INTERP, S_MUL, S_CORR_WAIT,
        S_SUM, S_DONE
    } tlin_state_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic signed [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DIV_NW-1:0] quo;
    } div_rsp_t;

endpackage

@@ rtl/tlin_if.sv @@
// Item channel interfaces of the thermistor table linearizer.
// Depends on nothing but plain logic types.
interface tlin_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  channel;
    logic [5:0]  word_index;
    logic signed [15:0] word_value;
    logic [9:0]  sensor_sample;
    logic [9:0]  supply_sample;

    modport source (output valid, req_type, channel, word_index, word_value,
                    sensor_sample, supply_sample, input ready);
    modport sink (input valid, req_type, channel, word_index, word_value,
                  sensor_sample, supply_sample, output ready);
endinterface

interface tlin_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] temperature;
    logic        calibrate_ok;

    modport source (output valid, temperature, calibrate_ok, input ready);
    modport sink (input valid, temperature, calibrate_ok, output ready);
endinterface

@@ rtl/tlin_div.sv @@
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tlin_pkg.
module tlin_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tlin_pkg::div_req_t cmd,
    output tlin_pkg::div_rsp_t stat
);
    localparam int NW = tlin_pkg::DIV_NW;
    localparam int DW = tlin_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic             neg_reg;

    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   trial;
    logic          fits;

    assign num_mag = cmd.num[NW-1] ? NW'(-cmd.num) : NW'(cmd.num);
    assign den_mag = cmd.den[DW-1] ? DW'(-cmd.den) : DW'(cmd.den);

    // restoring step
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits = trial >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk) begin
        if (cmd.start)
        begin
            quo_reg <= num_mag;
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= cmd.num[NW-1] ^ cmd.den[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quo  = neg_reg ? $signed(~quo_reg + NW'(1)) : $signed(quo_reg);

endmodule

@@ rtl/thermistor_table_linearizer.sv @@
// Top level of the thermistor table linearizer: APB registers, table memory,
// sequencer. Depends on tlin_pkg, tlin_if and tlin_div.
//
//  channel  kind         payload
//  req      item in      req_type channel word_index word_value sensor/supply
//  rsp      item out     temperature calibrate_ok
//  apb      config       channel_count ref_mode supply_div_top/bottom
//
// Convert uses up to two divisions on the shared divider (three in supply mode),
// calibrate up to one (two in supply mode). The table walk reads each entry passed
// from the one memory read port. Reset clears control state and offsets; the table
// is not cleared. A finished result waits in the output register; the next item is
// taken meanwhile.
module thermistor_table_linearizer #(
    parameter int CHANNELS = 4,
    parameter int WORDS_PER_CHANNEL = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlin_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    tlin_req_if.sink                    req,
    tlin_rsp_if.source                  rsp
);
    localparam int NW = tlin_pkg::DIV_NW;
    localparam int DW = tlin_pkg::DIV_DW;
    localparam int VW = tlin_pkg::VCC_W;
    localparam int RW = tlin_pkg::RES_W;
    localparam int PW = $clog2(WORDS_PER_CHANNEL) + 1;
    localparam int DEPTH = CHANNELS * WORDS_PER_CHANNEL;
    localparam int AW = $clog2(DEPTH);
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = NW + 2;
    localparam int BASE_W = 16 + PW + 1;

    // configuration registers
    logic [2:0]  channel_count_reg;
    logic [1:0]  ref_mode_reg;
    logic [15:0] div_top_reg;
    logic [15:0] div_bottom_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            channel_count_reg <= 3'd1;
            ref_mode_reg      <= 2'd1;
            div_top_reg       <= 16'd1;
            div_bottom_reg    <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                tlin_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[2:0];
                tlin_pkg::REG_REF_MODE:      ref_mode_reg      <= pwdata[1:0];
                tlin_pkg::REG_DIV_TOP:       div_top_reg       <= pwdata[15:0];
                tlin_pkg::REG_DIV_BOTTOM:    div_bottom_reg    <= pwdata[15:0];
                default:                     div_bottom_reg    <= div_bottom_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            tlin_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            tlin_pkg::REG_REF_MODE:      prdata = 32'(ref_mode_reg);
            tlin_pkg::REG_DIV_TOP:       prdata = 32'(div_top_reg);
            tlin_pkg::REG_DIV_BOTTOM:    prdata = 32'(div_bottom_reg);
            default:                     prdata = '0;
        endcase
    end

    // sequencer and datapath state
    tlin_pkg::tlin_state_t state_reg, state_next;
    logic        req_acc;
    logic        out_load;
    logic        out_valid_reg;
    logic signed [15:0] out_temp_reg;
    logic        out_ok_reg;

    logic [1:0]  type_reg;
    logic [1:0]  ch_reg;
    logic [9:0]  volt_reg;
    logic [9:0]  supply_reg;
    logic [VW-1:0] vcc_reg;
    logic signed [15:0] w0_reg, start_reg, step_reg, prev_reg, cur_reg;
    logic signed [NW-1:0] res_reg, corr_reg;
    logic signed [RW+15:0] prod_reg;
    logic [PW-1:0] p_reg;
    logic signed [15:0] temp_reg;
    logic        cal_ok_reg;
    logic [7:0]  cal_off_reg [CHANNELS];

    // table memory
    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rd_data_reg;
    logic [PW-1:0] rd_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          mem_we;

    tlin_pkg::div_req_t div_cmd;
    tlin_pkg::div_rsp_t div_stat;

    tlin_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    assign req_acc = req.valid && req.ready;
    assign mem_we = req_acc && (req.req_type == tlin_pkg::REQ_LOAD)
                    && (int'(req.channel) < CHANNELS)
                    && (int'(req.word_index) < WORDS_PER_CHANNEL);
    assign wr_addr = AW'(32'(req.channel) * WORDS_PER_CHANNEL + 32'(req.word_index));
    assign rd_addr = AW'(32'(ch_reg) * WORDS_PER_CHANNEL + 32'(rd_idx));

    always_ff @(posedge clk) begin
        if (mem_we)
        begin
            mem[wr_addr] <= req.word_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // arithmetic feeding the divider and the final sum
    logic        is_conv;
    logic        usable;
    logic        volt_sat;
    logic [16:0] div_sum;
    logic [VW-1:0] vcc_prod;
    logic signed [VW:0] vdiff;
    logic signed [VW+11:0] cal_prod;
    logic signed [16:0] w0_off;
    logic signed [27:0] conv_prod;
    logic signed [RW-1:0] res_diff;
    logic signed [16:0] seg_diff;
    logic signed [NW:0] cali;
    logic [PW-1:0] pm3;
    logic signed [BASE_W-1:0] base;
    logic signed [SUM_W-1:0] sum;
    logic signed [15:0] sat;
    logic walk_on;

    assign is_conv = type_reg == tlin_pkg::REQ_CONVERT;
    assign usable = (ch_reg < channel_count_reg) && (int'(ch_reg) < CHANNELS)
                    && !(ref_mode_reg == tlin_pkg::MODE_SUPPLY && div_bottom_reg == '0);
    assign div_sum = 17'(div_top_reg) + 17'(div_bottom_reg);
    assign vcc_prod = supply_reg * div_sum;
    assign vdiff = $signed({1'b0, vcc_reg}) - $signed((VW + 1)'(volt_reg));
    assign volt_sat = (VW'(volt_reg) >= vcc_reg);
    assign cal_prod = vdiff * tlin_pkg::CAL_SCALE;
    assign w0_off = 17'(w0_reg) + 17'($signed(cal_off_reg[CIW'(ch_reg)]));
    assign conv_prod = w0_off * $signed({1'b0, volt_reg});
    assign res_diff = RW'(res_reg) - RW'(cur_reg);
    assign seg_diff = 17'(cur_reg) - 17'(prev_reg);
    assign cali = (NW + 1)'(w0_reg) - (NW + 1)'(div_stat.quo);
    assign pm3 = p_reg - PW'(3);
    assign base = step_reg * $signed({1'b0, pm3});
    assign sum = SUM_W'(start_reg) + SUM_W'(base) + SUM_W'(corr_reg);
    assign walk_on = (NW'(cur_reg) < res_reg)
                     && (32'(p_reg) + 1 < WORDS_PER_CHANNEL);

    // saturate to the result range
    always_comb begin
        priority if (sum > SUM_W'(tlin_pkg::TEMP_MAX))
            sat = 16'sh7FFF;
        else if (sum < SUM_W'(tlin_pkg::TEMP_MIN))
            sat = -16'sh8000;
        else
            sat = 16'(sum);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tlin_pkg::S_IDLE:
                if (req_acc && (req.req_type == tlin_pkg::REQ_CONVERT
                                || req.req_type == tlin_pkg::REQ_CALIBRATE))
                    state_next = tlin_pkg::S_VCC;
            tlin_pkg::S_VCC:
                if (!usable)
                    state_next = tlin_pkg::S_DONE;
                else if (ref_mode_reg == tlin_pkg::MODE_SUPPLY)
                    state_next = tlin_pkg::S_VCC_WAIT;
                else
                    state_next = tlin_pkg::S_RD0;
            tlin_pkg::S_VCC_WAIT:
                if (div_stat.done)
                    state_next = tlin_pkg::S_RD0;
            tlin_pkg::S_RD0: state_next = tlin_pkg::S_RD1;
            tlin_pkg::S_RD1: state_next = tlin_pkg::S_RD2;
            tlin_pkg::S_RD2: state_next = tlin_pkg::S_RES;
            tlin_pkg::S_RES:
                if (is_conv ? volt_sat : (volt_reg == '0))
                    state_next = tlin_pkg::S_DONE;
                else
                    state_next = tlin_pkg::S_RES_WAIT;
            tlin_pkg::S_RES_WAIT:
                if (div_stat.done)
                    state_next = is_conv ? tlin_pkg::S_RD3 : tlin_pkg::S_DONE;
            tlin_pkg::S_RD3: state_next = tlin_pkg::S_RD4;
            tlin_pkg::S_RD4: state_next = tlin_pkg::S_CUR;
            tlin_pkg::S_CUR: state_next = tlin_pkg::S_CHK;
            tlin_pkg::S_CHK:
                state_next = walk_on ? tlin_pkg::S_NXT : tlin_pkg::S_INTERP;
            tlin_pkg::S_NXT:
                state_next = (rd_data_reg != '0) ? tlin_pkg::S_CHK : tlin_pkg::S_INTERP;
            tlin_pkg::S_INTERP:
                state_next = (cur_reg == prev_reg) ? tlin_pkg::S_SUM : tlin_pkg::S_MUL;
            tlin_pkg::S_MUL: state_next = tlin_pkg::S_CORR_WAIT;
            tlin_pkg::S_CORR_WAIT:
                if (div_stat.done)
                    state_next = tlin_pkg::S_SUM;
            tlin_pkg::S_SUM: state_next = tlin_pkg::S_DONE;
            tlin_pkg::S_DONE:
                if (!out_valid_reg || rsp.ready)
                    state_next = tlin_pkg::S_IDLE;
            default: state_next = tlin_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        req.ready = 1'b0;
        out_load = 1'b0;
        rd_idx = '0;
        div_cmd.start = 1'b0;
        div_cmd.num = '0;
        div_cmd.den = '0;
        unique case (state_reg)
            tlin_pkg::S_IDLE: req.ready = 1'b1;
            tlin_pkg::S_VCC:
            begin
                div_cmd.start = usable && (ref_mode_reg == tlin_pkg::MODE_SUPPLY);
                div_cmd.num = NW'($signed({1'b0, vcc_prod}));
                div_cmd.den = DW'($signed({1'b0, div_bottom_reg}));
            end
            tlin_pkg::S_RD0: rd_idx = PW'(0);
            tlin_pkg::S_RD1: rd_idx = PW'(1);
            tlin_pkg::S_RD2: rd_idx = PW'(2);
            tlin_pkg::S_RES:
            begin
                if (is_conv)
                begin
                    div_cmd.start = !volt_sat;
                    div_cmd.num = NW'(conv_prod);
                    div_cmd.den = DW'(vdiff);
                end
                else
                begin
                    div_cmd.start = volt_reg != '0;
                    div_cmd.num = NW'(cal_prod);
                    div_cmd.den = DW'($signed({1'b0, volt_reg}));
                end
            end
            tlin_pkg::S_RD3: rd_idx = PW'(3);
            tlin_pkg::S_RD4: rd_idx = PW'(4);
            tlin_pkg::S_CHK: rd_idx = p_reg + PW'(1);
            tlin_pkg::S_MUL:
            begin
                div_cmd.start = 1'b1;
                div_cmd.num = NW'(prod_reg);
                div_cmd.den = DW'(seg_diff);
            end
            tlin_pkg::S_DONE: out_load = !out_valid_reg || rsp.ready;
            default: req.ready = 1'b0;
        endcase
    end

    // control registers and offsets
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= tlin_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cal_off_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == tlin_pkg::S_RES_WAIT && div_stat.done && !is_conv
                && cali >= (NW + 1)'(tlin_pkg::CAL_MIN)
                && cali <= (NW + 1)'(tlin_pkg::CAL_MAX))
                cal_off_reg[CIW'(ch_reg)] <= cali[7:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk) begin
        unique case (state_reg)
            tlin_pkg::S_IDLE:
                if (req_acc)
                begin
                    type_reg   <= req.req_type;
                    ch_reg     <= req.channel;
                    volt_reg   <= req.sensor_sample;
                    supply_reg <= req.supply_sample;
                    temp_reg   <= '0;
                    cal_ok_reg <= 1'b0;
                    corr_reg   <= '0;
                end
            tlin_pkg::S_VCC:
                if (ref_mode_reg == tlin_pkg::MODE_SINGLE)
                    vcc_reg <= VW'(tlin_pkg::ADC_FULL_SCALE - 1);
                else
                    vcc_reg <= VW'(2 * tlin_pkg::ADC_FULL_SCALE - 1);
            tlin_pkg::S_VCC_WAIT:
                if (div_stat.done)
                    vcc_reg <= VW'(div_stat.quo);
            tlin_pkg::S_RD1: w0_reg <= rd_data_reg;
            tlin_pkg::S_RD2: start_reg <= rd_data_reg;
            tlin_pkg::S_RES: step_reg <= rd_data_reg;
            tlin_pkg::S_RES_WAIT:
                if (div_stat.done)
                begin
                    res_reg <= div_stat.quo;
                    cal_ok_reg <= !is_conv
                                  && cali >= (NW + 1)'(tlin_pkg::CAL_MIN)
                                  && cali <= (NW + 1)'(tlin_pkg::CAL_MAX);
                end
            tlin_pkg::S_RD4: prev_reg <= rd_data_reg;
            tlin_pkg::S_CUR:
            begin
                cur_reg <= rd_data_reg;
                p_reg <= PW'(4);
            end
            tlin_pkg::S_NXT:
                if (rd_data_reg != '0)
                begin
                    prev_reg <= cur_reg;
                    cur_reg <= rd_data_reg;
                    p_reg <= p_reg + PW'(1);
                end
            tlin_pkg::S_INTERP: prod_reg <= res_diff * step_reg;
            tlin_pkg::S_CORR_WAIT:
                if (div_stat.done)
                    corr_reg <= div_stat.quo;
            tlin_pkg::S_SUM: temp_reg <= sat;
            tlin_pkg::S_DONE:
                if (out_load)
                begin
                    out_temp_reg <= temp_reg;
                    out_ok_reg <= cal_ok_reg;
                end
            default: p_reg <= p_reg;
        endcase
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.temperature = out_temp_reg;
    assign rsp.calibrate_ok = out_ok_reg;

    // checks
    `include "thermistor_table_linearizer_assert.svh"

    `TLIN_ASSERT_IMP(a_idle_div_quiet, state_reg == tlin_pkg::S_IDLE, !div_stat.busy, "divider busy while idle")
    `TLIN_ASSERT_NXT(a_out_loaded, out_load, rsp.valid, "finished item not presented")
    `TLIN_ASSERT_IMP(a_cal_zero_temp, rsp.valid && rsp.calibrate_ok, rsp.temperature == '0, "calibrate result with temperature")
    `TLIN_ASSERT_IMP(a_walk_range, state_reg == tlin_pkg::S_CHK, p_reg >= PW'(4) && 32'(p_reg) < WORDS_PER_CHANNEL, "walk index out of channel block")

endmodule
